// ===== hw/rtl/sdvp_pkg.sv =====
// sdvp_pkg: shared constants, character codes and types of the sdi-12 value parser
// used by the channel interfaces and every rtl module of the block
package sdvp_pkg;

  localparam int VALUE_CHARS     = 9;
  localparam int VALUES_PER_RESP = 20;

  localparam int CHAR_W     = 8;
  localparam int MAG_W      = 27;
  localparam int MANT_W     = 28;
  localparam int DIG_W      = 3;
  localparam int IDX_W      = 5;
  localparam int TLEN_W     = $clog2(VALUE_CHARS + 1);
  localparam int FOUND_W    = $clog2(VALUES_PER_RESP + 1);
  localparam int HOLD_DEPTH = 3;
  localparam int HCNT_W     = $clog2(HOLD_DEPTH + 1);
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // number of characters an entry asks the parser to consume
  typedef enum logic [1:0] {
    NCH_NONE = 2'd0,
    NCH_ONE  = 2'd1,
    NCH_TWO  = 2'd2
  } nch_e;

  typedef struct packed {
    logic [CHAR_W-1:0] c0;
    logic [CHAR_W-1:0] c1;
    nch_e              nch;
    logic              last;
  } entry_t;

  typedef struct packed {
    logic              in_value;
    logic [TLEN_W-1:0] text_length;
    logic              negative;
    logic [MAG_W-1:0]  magnitude;
    logic              point_seen;
    logic              digits_frozen;
    logic [DIG_W-1:0]  scale;
    logic [DIG_W-1:0]  after_point;
  } val_t;

  typedef struct packed {
    logic                     valid;
    logic signed [MANT_W-1:0] mant;
    logic [DIG_W-1:0]         pdig;
    logic [DIG_W-1:0]         dec;
    logic [IDX_W-1:0]         idx;
  } pend_t;

endpackage

// ===== hw/rtl/sdvp_in_if.sv =====
// sdvp_in_if: character channel of the sdi-12 value parser
// depends on sdvp_pkg for field widths
interface sdvp_in_if;
  logic                         valid;
  logic                         ready;
  logic [sdvp_pkg::CHAR_W-1:0]  ch;
  logic                         last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== hw/rtl/sdvp_out_if.sv =====
// sdvp_out_if: result channel of the sdi-12 value parser
// depends on sdvp_pkg for field widths
interface sdvp_out_if;
  logic                                valid;
  logic                                ready;
  logic                                has_value;
  logic signed [sdvp_pkg::MANT_W-1:0]  value_mantissa;
  logic [sdvp_pkg::DIG_W-1:0]          point_digits;
  logic [sdvp_pkg::DIG_W-1:0]          decimals;
  logic [sdvp_pkg::IDX_W-1:0]          value_index;
  logic                                end_of_response;
  logic [sdvp_pkg::IDX_W-1:0]          found_count;

  modport source (output valid, output has_value, output value_mantissa,
                  output point_digits, output decimals, output value_index,
                  output end_of_response, output found_count, input ready);
  modport sink   (input valid, input has_value, input value_mantissa,
                  input point_digits, input decimals, input value_index,
                  input end_of_response, input found_count, output ready);
endinterface

// ===== hw/rtl/sdvp_front.sv =====
// sdvp_front: accepts characters, runs the three-deep crc holding line and
// decides which characters reach the parser; depends on sdvp_pkg, sdvp_in_if
module sdvp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             strip_i,
  sdvp_in_if.sink          in_i,
  input  logic             full_i,
  output logic             push_o,
  output sdvp_pkg::entry_t entry_o
);
  import sdvp_pkg::*;

  logic [CHAR_W-1:0] held_q [HOLD_DEPTH];
  logic [CHAR_W-1:0] held_d [HOLD_DEPTH];
  logic [HCNT_W-1:0] cnt_q, cnt_d;
  logic              accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    entry_o = '0;
    push_o  = 1'b0;
    held_d  = held_q;
    cnt_d   = cnt_q;
    if (accept) begin
      entry_o.last = in_i.last;
      if (!strip_i) begin
        entry_o.nch = NCH_ONE;
        entry_o.c0  = in_i.ch;
        push_o      = 1'b1;
        cnt_d       = '0;
      end else if (!in_i.last) begin
        if (cnt_q < HCNT_W'(HOLD_DEPTH)) begin
          held_d[cnt_q] = in_i.ch;
          cnt_d         = cnt_q + 1'b1;
        end else begin
          entry_o.nch = NCH_ONE;
          entry_o.c0  = held_q[0];
          push_o      = 1'b1;
          for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
            held_d[i] = held_q[i+1];
          end
          held_d[HOLD_DEPTH-1] = in_i.ch;
        end
      end else begin
        // last character: the final three of the response are crc
        push_o = 1'b1;
        if (cnt_q >= HCNT_W'(HOLD_DEPTH)) begin
          entry_o.nch = NCH_ONE;
          entry_o.c0  = held_q[0];
        end else if (cnt_q == HCNT_W'(HOLD_DEPTH - 1)) begin
          entry_o.nch = NCH_NONE;
        end else if (cnt_q == HCNT_W'(1)) begin
          // short response, parsed in full
          entry_o.nch = NCH_TWO;
          entry_o.c0  = held_q[0];
          entry_o.c1  = in_i.ch;
        end else begin
          entry_o.nch = NCH_ONE;
          entry_o.c0  = in_i.ch;
        end
      end
      if (in_i.last) begin
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

// ===== hw/rtl/sdvp_fifo.sv =====
// sdvp_fifo: short queue of parse entries between front and back
// depends on sdvp_pkg
module sdvp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sdvp_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output sdvp_pkg::entry_t head_o
);
  import sdvp_pkg::*;

  entry_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o       = (count_q == FCNT_W'(FIFO_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== hw/rtl/sdvp_back.sv =====
// sdvp_back: value parser that consumes queue entries and drives the result register
// depends on sdvp_pkg and sdvp_out_if
module sdvp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  sdvp_pkg::entry_t head_i,
  output logic             pop_o,
  sdvp_out_if.source       out_o
);
  import sdvp_pkg::*;

  val_t               st_q, st_d;
  pend_t              pend_q, pend_d;
  logic [FOUND_W-1:0] found_q, found_d, found_cur;
  logic               sub_q;
  logic               final_step, emit, out_free, advance;
  logic [CHAR_W-1:0]  c;
  logic               is_digit, is_point, is_sign, done;

  logic                     ovalid_q;
  pend_t                    opend_q;
  logic                     oend_q;
  logic [IDX_W-1:0]         ocount_q;

  function automatic logic completes(input val_t v);
    return v.in_value && (v.text_length >= TLEN_W'(2));
  endfunction

  function automatic pend_t make_pend(input val_t v, input logic [FOUND_W-1:0] f);
    pend_t p;
    p.valid = 1'b1;
    p.mant  = v.negative ? -$signed({1'b0, v.magnitude}) : $signed({1'b0, v.magnitude});
    p.pdig  = v.scale;
    p.dec   = v.after_point;
    p.idx   = IDX_W'(f);
    return p;
  endfunction

  // a short response with stripping takes two passes, one per character
  assign final_step = (head_i.nch != NCH_TWO) || sub_q;
  assign c          = sub_q ? head_i.c1 : head_i.c0;
  assign is_digit   = c inside {[CH_ZERO:CH_NINE]};
  assign is_point   = (c == CH_POINT);
  assign is_sign    = (c == CH_PLUS) || (c == CH_MINUS);

  always_comb begin
    st_d      = st_q;
    found_cur = found_q;
    pend_d    = sub_q ? pend_q : '0;
    done      = 1'b0;
    if (head_i.nch != NCH_NONE) begin
      if (st_d.in_value) begin
        if (is_digit || is_point) begin
          done = 1'b1;
          if (st_d.text_length < TLEN_W'(VALUE_CHARS)) begin
            st_d.text_length = st_d.text_length + 1'b1;
            if (is_digit) begin
              if (!st_d.digits_frozen) begin
                st_d.magnitude = st_d.magnitude * MAG_W'(10) + MAG_W'(c[3:0]);
                if (st_d.point_seen) st_d.scale = st_d.scale + 1'b1;
              end
              if (st_d.point_seen) st_d.after_point = st_d.after_point + 1'b1;
            end else if (st_d.point_seen) begin
              // second point stops the mantissa but still counts as a decimal
              st_d.after_point   = st_d.after_point + 1'b1;
              st_d.digits_frozen = 1'b1;
            end else begin
              st_d.point_seen = 1'b1;
            end
          end
        end else begin
          if (completes(st_d)) begin
            pend_d    = make_pend(st_d, found_cur);
            found_cur = found_cur + 1'b1;
          end
          st_d = '0;
        end
      end
      if (!done && (found_cur < FOUND_W'(VALUES_PER_RESP)) && is_sign) begin
        st_d             = '0;
        st_d.in_value    = 1'b1;
        st_d.negative    = (c == CH_MINUS);
        st_d.text_length = TLEN_W'(1);
      end
    end
    if (final_step && head_i.last) begin
      if (completes(st_d)) begin
        pend_d    = make_pend(st_d, found_cur);
        found_cur = found_cur + 1'b1;
      end
      st_d = '0;
    end
    found_d = (final_step && head_i.last) ? '0 : found_cur;
  end

  assign emit     = final_step && (pend_d.valid || head_i.last);
  assign out_free = !ovalid_q || out_o.ready;
  assign advance  = head_valid_i && (!emit || out_free);
  assign pop_o    = advance && final_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= '0;
      found_q  <= '0;
      sub_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (advance) begin
        st_q    <= st_d;
        found_q <= found_d;
        sub_q   <= !final_step;
      end
      if (advance && emit) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) pend_q <= pend_d;
    if (advance && emit) begin
      opend_q  <= pend_d;
      oend_q   <= head_i.last;
      ocount_q <= IDX_W'(found_cur);
    end
  end

  assign out_o.valid           = ovalid_q;
  assign out_o.has_value       = opend_q.valid;
  assign out_o.value_mantissa  = opend_q.mant;
  assign out_o.point_digits    = opend_q.pdig;
  assign out_o.decimals        = opend_q.dec;
  assign out_o.value_index     = opend_q.idx;
  assign out_o.end_of_response = oend_q;
  assign out_o.found_count     = ocount_q;

endmodule

// ===== hw/rtl/sdvp_top.sv =====
// Parses the numeric values out of an SDI-12 data response (address already removed),
// one character per transaction, and reports each value as an exact decimal
// mantissa * 10^-point_digits. It sustains one character per clock unless the result
// channel stalls or a stripped two-character response needs a second pass. Each entry
// is registered in the entry queue; the parser loads the result register. With crc
// stripping on, the last three characters wait in a three-deep line, so a value
// closes three characters after its text. No clearing pass follows reset. The user
// writes strip_crc via cfg_we_i/cfg_wdata_i only while no transaction is in flight;
// the block does not enforce this. Depends on sdvp_pkg, sdvp_in_if, sdvp_out_if,
// sdvp_front, sdvp_fifo, sdvp_back.
module sdi12_data_value_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  sdvp_in_if.sink    in_i,
  sdvp_out_if.source out_o
);
  import sdvp_pkg::*;

  logic   strip_q;
  logic   push, full, pop, head_valid;
  entry_t entry, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= 1'b0;
    end else if (cfg_we_i) begin
      strip_q <= cfg_wdata_i;
    end
  end

  sdvp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .strip_i (strip_q),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  sdvp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  sdvp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

`ifndef SYNTHESIS
  // a value always counts itself
  a_index_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.has_value |-> out_o.value_index < out_o.found_count)
    else $error("value_index not below found_count");

  // results without a value only close a response
  a_empty_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.has_value |-> out_o.end_of_response &&
      out_o.value_mantissa == '0 && out_o.point_digits == '0 && out_o.decimals == '0)
    else $error("result without value is not an end result");

  // mantissa digits after the point never exceed the decimals
  a_scale_le_decimals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.has_value |-> out_o.point_digits <= out_o.decimals)
    else $error("point_digits above decimals");

  // the front never pushes into a full queue
  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("entry pushed into full queue");
`endif

endmodule

// ===== bench/sdvp_value_checker.sv =====
// sdvp_value_checker: watches the character and result channels of the sdi-12 value parser,
// predicts every result from the accepted characters and compares them in order
// depends on sdvp_pkg, sdvp_in_if and sdvp_out_if
module sdvp_value_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  sdvp_in_if   in_mon,
  sdvp_out_if  out_mon,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   checked_o,
  output int   values_o
);
  import sdvp_pkg::*;

  typedef struct packed {
    logic                     has_value;
    logic signed [MANT_W-1:0] mantissa;
    logic [DIG_W-1:0]         point_digits;
    logic [DIG_W-1:0]         decimals;
    logic [IDX_W-1:0]         value_index;
    logic                     end_of_response;
    logic [IDX_W-1:0]         found_count;
  } parse_result_t;

  parse_result_t     parse_results_q[$];
  parse_result_t     got, want;

  logic              strip_q;
  logic [CHAR_W-1:0] held_q[HOLD_DEPTH];
  logic [HCNT_W-1:0] held_n;
  val_t              value_st;
  logic [FOUND_W-1:0] found_q;
  pend_t             closed_v;
  int                fails, checked, values;

  function automatic void emit_value();
    logic [MANT_W-1:0] mag;
    if (value_st.in_value && value_st.text_length >= 2) begin
      mag = MANT_W'(value_st.magnitude);
      closed_v.valid = 1'b1;
      closed_v.mant  = value_st.negative ? (~mag + 1'b1) : mag;
      closed_v.pdig  = value_st.scale;
      closed_v.dec   = value_st.after_point;
      closed_v.idx   = IDX_W'(found_q);
      found_q++;
    end
    value_st = '0;
  endfunction

  function automatic void take_char(input logic [CHAR_W-1:0] c);
    logic is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (value_st.in_value) begin
      if (is_digit || c == CH_POINT) begin
        // text past VALUE_CHARS is dropped but still keeps the value open
        if (value_st.text_length < VALUE_CHARS) begin
          value_st.text_length++;
          if (is_digit) begin
            if (!value_st.digits_frozen) begin
              value_st.magnitude = MAG_W'(value_st.magnitude * 10 + (c - CH_ZERO));
              if (value_st.point_seen) value_st.scale++;
            end
            if (value_st.point_seen) value_st.after_point++;
          end else if (value_st.point_seen) begin
            value_st.after_point++;
            value_st.digits_frozen = 1'b1;
          end else begin
            value_st.point_seen = 1'b1;
          end
        end
        return;
      end
      emit_value();
    end
    if (found_q >= VALUES_PER_RESP) return;
    if (c == CH_PLUS || c == CH_MINUS) begin
      value_st             = '0;
      value_st.in_value    = 1'b1;
      value_st.negative    = (c == CH_MINUS);
      value_st.text_length = 1;
    end
  endfunction

  function automatic void predict_parse(input logic [CHAR_W-1:0] c, input logic lst);
    parse_result_t r;
    closed_v = '0;
    if (!strip_q) begin
      held_n = '0;
      take_char(c);
    end else if (!lst) begin
      if (held_n < HOLD_DEPTH) begin
        held_q[held_n] = c;
        held_n++;
      end else begin
        take_char(held_q[0]);
        held_q[0] = held_q[1];
        held_q[1] = held_q[2];
        held_q[2] = c;
      end
    end else begin
      // the three newest characters are crc; short responses are parsed whole
      if (held_n >= HOLD_DEPTH) begin
        take_char(held_q[0]);
      end else if (held_n < 2) begin
        for (int i = 0; i < int'(held_n); i++) take_char(held_q[i]);
        take_char(c);
      end
    end
    if (lst) emit_value();
    if (closed_v.valid || lst) begin
      r.has_value       = closed_v.valid;
      r.mantissa        = closed_v.mant;
      r.point_digits    = closed_v.pdig;
      r.decimals        = closed_v.dec;
      r.value_index     = closed_v.idx;
      r.end_of_response = lst;
      r.found_count     = IDX_W'(found_q);
      parse_results_q.push_back(r);
      if (closed_v.valid) values++;
    end
    if (lst) begin
      held_n   = '0;
      held_q   = '{default: '0};
      value_st = '0;
      found_q  = '0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q  = 1'b0;
      held_n   = '0;
      held_q   = '{default: '0};
      value_st = '0;
      found_q  = '0;
      parse_results_q.delete();
      fails    = 0;
      checked  = 0;
      values   = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
      checked_o  <= 0;
      values_o   <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.has_value       = out_mon.has_value;
        got.mantissa        = out_mon.value_mantissa;
        got.point_digits    = out_mon.point_digits;
        got.decimals        = out_mon.decimals;
        got.value_index     = out_mon.value_index;
        got.end_of_response = out_mon.end_of_response;
        got.found_count     = out_mon.found_count;
        if (parse_results_q.size() == 0) begin
          $display("%0t: unexpected result transaction, mantissa %0d count %0d", $time,
                   $signed(got.mantissa), got.found_count);
          fails++;
        end else begin
          want = parse_results_q.pop_front();
          checked++;
          if (got !== want) begin
            $display({"%0t: result mismatch, expected has=%0b mant=%0d pdig=%0d dec=%0d ",
                      "idx=%0d end=%0b cnt=%0d, actual has=%0b mant=%0d pdig=%0d dec=%0d ",
                      "idx=%0d end=%0b cnt=%0d"}, $time,
                     want.has_value, $signed(want.mantissa), want.point_digits,
                     want.decimals, want.value_index, want.end_of_response,
                     want.found_count, got.has_value, $signed(got.mantissa),
                     got.point_digits, got.decimals, got.value_index,
                     got.end_of_response, got.found_count);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) predict_parse(in_mon.ch, in_mon.last);
      if (cfg_we_i) strip_q = cfg_wdata_i;
      fail_cnt_o <= fails;
      pending_o  <= parse_results_q.size();
      checked_o  <= checked;
      values_o   <= values;
    end
  end

endmodule

// ===== bench/tb_sdi12_data_value_parser_top.sv =====
// tb_sdi12_data_value_parser_top: drives sdi-12 response characters and crc settings into the
// value parser with random gaps and output stalls; sdvp_value_checker does the checking
// depends on sdvp_pkg, sdvp_in_if, sdvp_out_if, sdvp_value_checker and the parser rtl
module tb_sdi12_data_value_parser_top;
  import sdvp_pkg::*;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int CHAR_TARGET  = 1350;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  sdvp_in_if  in_ch ();
  sdvp_out_if out_ch ();

  int n_fail, n_pending, n_checked, n_values;
  int chars_sent, responses_sent;
  int quiet_cycles = 0;
  bit src_idle_on, sink_idle_on;
  logic [CHAR_W-1:0] resp_q[$];

  sdi12_data_value_parser_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  sdvp_value_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_cnt_o  (n_fail),
    .pending_o   (n_pending),
    .checked_o   (n_checked),
    .values_o    (n_values)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // valid stays high between back-to-back characters
  task automatic put_char(input logic [CHAR_W-1:0] c, input logic lst);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.ch    <= c;
    in_ch.last  <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
    chars_sent++;
  endtask

  task automatic send_resp(input bit closes);
    for (int i = 0; i < resp_q.size(); i++) put_char(resp_q[i], closes && i == resp_q.size() - 1);
    if (closes) responses_sent++;
  endtask

  task automatic send_text(input string s, input bit closes);
    resp_q.delete();
    for (int i = 0; i < s.len(); i++) resp_q.push_back(CHAR_W'(s[i]));
    send_resp(closes);
  endtask

  // wait for every predicted result, then for characters that cause none
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (n_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_strip(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic build_response();
    int kind, nvals, sep;
    bit nines;
    resp_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) resp_q.push_back(CHAR_W'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 3))
          0:       resp_q.push_back(CH_PLUS);
          1:       resp_q.push_back(CH_MINUS);
          2:       resp_q.push_back(CH_POINT);
          default: resp_q.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
        endcase
      end
    end else begin
      // now and then enough values to run into the per-response limit
      nvals = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 23) : $urandom_range(0, 6);
      repeat (nvals) begin
        resp_q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        nines = ($urandom_range(0, 7) == 0);
        repeat ($urandom_range(0, 10)) begin
          if (nines) resp_q.push_back(CH_NINE);
          else if ($urandom_range(0, 6) == 0) resp_q.push_back(CH_POINT);
          else resp_q.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
        end
        sep = $urandom_range(0, 5);
        if (sep == 0) resp_q.push_back(CHAR_W'($urandom_range(0, 255)));
        else if (sep < 3) resp_q.push_back(CH_SPACE);
      end
      // crc characters sit in 0x40..0x7f
      if ($urandom_range(0, 1)) repeat (3) resp_q.push_back(CHAR_W'($urandom_range(64, 127)));
    end
  endtask

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = sink_idle_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  initial begin
    int phase_end, cut;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.ch    = '0;
    in_ch.last  = 1'b0;
    chars_sent     = 0;
    responses_sent = 0;
    src_idle_on    = 1'b0;
    sink_idle_on   = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sign alone, bare point, second point, truncation and the widest fraction
    send_text("+", 1'b1);
    send_text("+.-1.2.3", 1'b1);
    sink_idle_on = 1'b1;
    send_text("-999999999+.9999999", 1'b1);
    settle();
    set_strip(1'b1);
    src_idle_on = 1'b1;
    send_text("+5", 1'b1);
    send_text("+12", 1'b1);
    send_text("-4", 1'b0);
    settle();
    // stripping off while two characters still sit in the hold line
    set_strip(1'b0);
    send_text("7-8", 1'b1);

    while (chars_sent < CHAR_TARGET) begin
      settle();
      set_strip($urandom_range(0, 1));
      phase_end = chars_sent + $urandom_range(80, 200);
      while (chars_sent < phase_end) begin
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
        build_response();
        send_resp(1'b1);
      end
      // leave a response open across the next setting change
      if ($urandom_range(0, 2) == 0) begin
        build_response();
        cut = $urandom_range(1, resp_q.size());
        while (resp_q.size() > cut) void'(resp_q.pop_back());
        send_resp(1'b0);
      end
    end
    settle();

    $display("run: %0d characters over %0d closed responses, crc stripping on and off",
             chars_sent, responses_sent);
    $display("run: %0d results compared, %0d of them carrying a value", n_checked, n_values);
    if (n_fail == 0 && n_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
